FILE: hw/rtl/lpds_pkg.sv
package lpds_pkg;

  // Function codes of an input item
  localparam logic [1:0] FuncAdd   = 2'd0;
  localparam logic [1:0] FuncRead  = 2'd1;
  localparam logic [1:0] FuncClear = 2'd2;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegMinSide = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMaxSide = 2'd1;

  localparam logic [15:0] MinSideReset = 16'd2000;
  localparam logic [15:0] MaxSideReset = 16'd20000;

  // Coordinate and squared distance widths
  localparam int unsigned CoordW = 20;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned SqW    = 2 * DiffW - 1;
  localparam int unsigned SumW   = SqW + 1;
  localparam int unsigned DistW  = 32;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [CoordW-1:0] landmark_x;
    logic signed [CoordW-1:0] landmark_y;
    logic [6:0]               rank;
  } in_item_t;

  typedef struct packed {
    logic             store_full;
    logic [3:0]       new_landmark_index;
    logic [3:0]       pairs_added;
    logic [6:0]       pair_total;
    logic             entry_valid;
    logic [3:0]       lower_index;
    logic [3:0]       upper_index;
    logic [DistW-1:0] distance_sq;
  } out_item_t;

  // Broadcast control for the row of sort cells
  typedef struct packed {
    logic             insert;
    logic             rd_load;
    logic             rd_shift;
    logic [DistW-1:0] cmp_dist;
  } chain_ctrl_t;

endpackage

FILE: hw/rtl/lpds_cell.sv
module lpds_cell #(
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned CNT_W    = 7,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                       clk_i,
  input  lpds_pkg::chain_ctrl_t      ctrl_i,
  input  logic [CNT_W-1:0]           pair_count_i,
  input  logic [IDX_W-1:0]           new_lower_i,
  input  logic [IDX_W-1:0]           new_upper_i,
  // neighbour towards rank 0
  input  logic                       prev_ge_i,
  input  logic [IDX_W-1:0]           prev_lower_i,
  input  logic [IDX_W-1:0]           prev_upper_i,
  input  logic [lpds_pkg::DistW-1:0] prev_dist_i,
  output logic                       ge_o,
  output logic [IDX_W-1:0]           lower_o,
  output logic [IDX_W-1:0]           upper_o,
  output logic [lpds_pkg::DistW-1:0] dist_o,
  // read-out line, moving towards rank 0
  input  logic [IDX_W-1:0]           rd_next_lower_i,
  input  logic [IDX_W-1:0]           rd_next_upper_i,
  input  logic [lpds_pkg::DistW-1:0] rd_next_dist_i,
  output logic [IDX_W-1:0]           rd_lower_o,
  output logic [IDX_W-1:0]           rd_upper_o,
  output logic [lpds_pkg::DistW-1:0] rd_dist_o
);
  import lpds_pkg::*;

  logic [IDX_W-1:0] lower_q, upper_q, rd_lower_q, rd_upper_q;
  logic [DistW-1:0] dist_q, rd_dist_q;
  logic             occupied;

  // An occupied entry at least as long as the new pair stays put
  assign occupied = pair_count_i > CNT_W'(CELL_IDX);
  assign ge_o     = occupied && (dist_q >= ctrl_i.cmp_dist);

  // Keep, take the new pair, or take the neighbour's entry
  always_ff @(posedge clk_i) begin
    if (ctrl_i.insert && !ge_o) begin
      if (prev_ge_i) begin
        lower_q <= new_lower_i;
        upper_q <= new_upper_i;
        dist_q  <= ctrl_i.cmp_dist;
      end else begin
        lower_q <= prev_lower_i;
        upper_q <= prev_upper_i;
        dist_q  <= prev_dist_i;
      end
    end
  end

  // Snapshot the entry, then advance it one place per cycle while rd_shift is set
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_load) begin
      rd_lower_q <= lower_q;
      rd_upper_q <= upper_q;
      rd_dist_q  <= dist_q;
    end else if (ctrl_i.rd_shift) begin
      rd_lower_q <= rd_next_lower_i;
      rd_upper_q <= rd_next_upper_i;
      rd_dist_q  <= rd_next_dist_i;
    end
  end

  assign lower_o    = lower_q;
  assign upper_o    = upper_q;
  assign dist_o     = dist_q;
  assign rd_lower_o = rd_lower_q;
  assign rd_upper_o = rd_upper_q;
  assign rd_dist_o  = rd_dist_q;

endmodule

FILE: hw/rtl/lpds_dist.sv
module lpds_dist #(
  parameter int unsigned MAX_LANDMARKS = 16,
  parameter int unsigned IDX_W         = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // landmark store write
  input  logic                               wr_en_i,
  input  logic [IDX_W-1:0]                   wr_idx_i,
  input  logic signed [lpds_pkg::CoordW-1:0] wr_x_i,
  input  logic signed [lpds_pkg::CoordW-1:0] wr_y_i,
  // one earlier landmark per issue
  input  logic                               issue_i,
  input  logic [IDX_W-1:0]                   issue_idx_i,
  input  logic signed [lpds_pkg::CoordW-1:0] new_x_i,
  input  logic signed [lpds_pkg::CoordW-1:0] new_y_i,
  input  logic [lpds_pkg::DistW-1:0]         lo2_i,
  input  logic [lpds_pkg::DistW-1:0]         hi2_i,
  output logic                               res_valid_o,
  output logic                               res_keep_o,
  output logic [IDX_W-1:0]                   res_idx_o,
  output logic [lpds_pkg::DistW-1:0]         res_dist_o,
  output logic                               busy_o
);
  import lpds_pkg::*;

  logic signed [CoordW-1:0] mem_x [MAX_LANDMARKS];
  logic signed [CoordW-1:0] mem_y [MAX_LANDMARKS];

  logic                     v1_q, v2_q, v3_q, v4_q;
  logic [IDX_W-1:0]         e1_q, e2_q, e3_q, e4_q;
  logic signed [CoordW-1:0] px_q, py_q;
  logic signed [DiffW-1:0]  dx_q, dy_q;
  logic signed [2*DiffW-1:0] prod_x, prod_y;
  logic [SqW-1:0]           sqx_q, sqy_q;
  logic [SumW-1:0]          sum;
  logic                     keep_q;
  logic [DistW-1:0]         dist_q;

  // Landmark store: write on add, registered read per issue
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_x[wr_idx_i] <= wr_x_i;
      mem_y[wr_idx_i] <= wr_y_i;
    end
    if (issue_i) begin
      px_q <= mem_x[issue_idx_i];
      py_q <= mem_y[issue_idx_i];
    end
  end

  assign prod_x = dx_q * dx_q;
  assign prod_y = dy_q * dy_q;
  assign sum    = {1'b0, sqx_q} + {1'b0, sqy_q};

  // Difference, square, then sum with window test, one stage each
  always_ff @(posedge clk_i) begin
    e1_q   <= issue_idx_i;
    dx_q   <= DiffW'(new_x_i) - DiffW'(px_q);
    dy_q   <= DiffW'(new_y_i) - DiffW'(py_q);
    e2_q   <= e1_q;
    sqx_q  <= prod_x[SqW-1:0];
    sqy_q  <= prod_y[SqW-1:0];
    e3_q   <= e2_q;
    keep_q <= (sum >= SumW'(lo2_i)) && (sum <= SumW'(hi2_i));
    dist_q <= sum[DistW-1:0];
    e4_q   <= e3_q;
  end

  // Advance the stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= issue_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  assign res_valid_o = v4_q;
  assign res_keep_o  = keep_q;
  assign res_idx_o   = e4_q;
  assign res_dist_o  = dist_q;
  assign busy_o      = v1_q | v2_q | v3_q | v4_q;

endmodule

FILE: hw/rtl/landmark_pair_distance_sorter.sv
// Landmark pair distance sorter. Holds up to MAX_LANDMARKS landmark positions
// and a list of up to PAIR_CAPACITY landmark pairs sorted by descending
// squared distance, kept in a row of sort cells that all compare against the
// new pair at once and shift by one place. On an add, the squared distance to
// each earlier landmark leaves a four-stage read/subtract/square/compare
// pipeline fed one landmark per cycle, and each kept pair is inserted into the
// cell row as it leaves the pipeline while there is room. A read of rank r
// snapshots the cell entries into a read-out line that moves one place towards
// rank 0 per cycle until entry r reaches rank 0. Clear, a rejected add, an
// out-of-range read and the unused function code go straight to the finish
// state. One item is worked at a time; a finished result waits in the output
// register while the next item is accepted. Configuration writes are always
// ready and apply to the next add.
module landmark_pair_distance_sorter #(
  parameter int unsigned MAX_LANDMARKS = 16,
  parameter int unsigned PAIR_CAPACITY = 120
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  lpds_pkg::in_item_t               in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output lpds_pkg::out_item_t              out_item_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lpds_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [15:0]                      cfg_data_i
);
  import lpds_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_LANDMARKS);
  localparam int unsigned PC_W  = $clog2(MAX_LANDMARKS + 1);
  localparam int unsigned CNT_W = $clog2(PAIR_CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > 7) ? CNT_W : 7;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StAdd    = 2'd1;
  localparam logic [1:0] StRead   = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  logic [1:0]               state_q, state_d;
  logic [PC_W-1:0]          point_count_q, point_count_d;
  logic [CNT_W-1:0]         pair_count_q, pair_count_d;
  logic [IDX_W-1:0]         idx_q, idx_d, issue_q, issue_d, added_q, added_d;
  logic [6:0]               rank_cnt_q, rank_cnt_d;
  logic signed [CoordW-1:0] new_x_q, new_x_d, new_y_q, new_y_d;
  logic [DistW-1:0]         lo2_q, lo2_d, hi2_q, hi2_d;
  logic [15:0]              win_lo_q, win_hi_q;
  out_item_t                pend_q, pend_d, out_q, out_d;
  logic                     out_valid_q, out_valid_d;

  chain_ctrl_t              ctrl;
  logic                     dist_wr, dist_issue;
  logic                     dres_valid, dres_keep, dist_busy;
  logic [IDX_W-1:0]         dres_idx;
  logic [DistW-1:0]         dres_dist;

  logic                     cell_ge     [PAIR_CAPACITY];
  logic [IDX_W-1:0]         cell_lower  [PAIR_CAPACITY];
  logic [IDX_W-1:0]         cell_upper  [PAIR_CAPACITY];
  logic [DistW-1:0]         cell_dist   [PAIR_CAPACITY];
  logic [IDX_W-1:0]         rd_lower    [PAIR_CAPACITY];
  logic [IDX_W-1:0]         rd_upper    [PAIR_CAPACITY];
  logic [DistW-1:0]         rd_dist     [PAIR_CAPACITY];

  // Distance pipeline with the landmark store
  lpds_dist #(
    .MAX_LANDMARKS (MAX_LANDMARKS),
    .IDX_W         (IDX_W)
  ) u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (dist_wr),
    .wr_idx_i    (IDX_W'(point_count_q)),
    .wr_x_i      (in_item_i.landmark_x),
    .wr_y_i      (in_item_i.landmark_y),
    .issue_i     (dist_issue),
    .issue_idx_i (issue_q),
    .new_x_i     (new_x_q),
    .new_y_i     (new_y_q),
    .lo2_i       (lo2_q),
    .hi2_i       (hi2_q),
    .res_valid_o (dres_valid),
    .res_keep_o  (dres_keep),
    .res_idx_o   (dres_idx),
    .res_dist_o  (dres_dist),
    .busy_o      (dist_busy)
  );

  // Row of sort cells, rank 0 first
  for (genvar i = 0; i < PAIR_CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      lpds_cell #(
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W),
        .CELL_IDX (i)
      ) u_cell (
        .clk_i           (clk_i),
        .ctrl_i          (ctrl),
        .pair_count_i    (pair_count_q),
        .new_lower_i     (dres_idx),
        .new_upper_i     (idx_q),
        .prev_ge_i       (1'b1),
        .prev_lower_i    ('0),
        .prev_upper_i    ('0),
        .prev_dist_i     ('0),
        .ge_o            (cell_ge[i]),
        .lower_o         (cell_lower[i]),
        .upper_o         (cell_upper[i]),
        .dist_o          (cell_dist[i]),
        .rd_next_lower_i (rd_lower[i+1]),
        .rd_next_upper_i (rd_upper[i+1]),
        .rd_next_dist_i  (rd_dist[i+1]),
        .rd_lower_o      (rd_lower[i]),
        .rd_upper_o      (rd_upper[i]),
        .rd_dist_o       (rd_dist[i])
      );
    end else if (i == PAIR_CAPACITY - 1) begin : g_tail
      lpds_cell #(
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W),
        .CELL_IDX (i)
      ) u_cell (
        .clk_i           (clk_i),
        .ctrl_i          (ctrl),
        .pair_count_i    (pair_count_q),
        .new_lower_i     (dres_idx),
        .new_upper_i     (idx_q),
        .prev_ge_i       (cell_ge[i-1]),
        .prev_lower_i    (cell_lower[i-1]),
        .prev_upper_i    (cell_upper[i-1]),
        .prev_dist_i     (cell_dist[i-1]),
        .ge_o            (cell_ge[i]),
        .lower_o         (cell_lower[i]),
        .upper_o         (cell_upper[i]),
        .dist_o          (cell_dist[i]),
        .rd_next_lower_i ('0),
        .rd_next_upper_i ('0),
        .rd_next_dist_i  ('0),
        .rd_lower_o      (rd_lower[i]),
        .rd_upper_o      (rd_upper[i]),
        .rd_dist_o       (rd_dist[i])
      );
    end else begin : g_mid
      lpds_cell #(
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W),
        .CELL_IDX (i)
      ) u_cell (
        .clk_i           (clk_i),
        .ctrl_i          (ctrl),
        .pair_count_i    (pair_count_q),
        .new_lower_i     (dres_idx),
        .new_upper_i     (idx_q),
        .prev_ge_i       (cell_ge[i-1]),
        .prev_lower_i    (cell_lower[i-1]),
        .prev_upper_i    (cell_upper[i-1]),
        .prev_dist_i     (cell_dist[i-1]),
        .ge_o            (cell_ge[i]),
        .lower_o         (cell_lower[i]),
        .upper_o         (cell_upper[i]),
        .dist_o          (cell_dist[i]),
        .rd_next_lower_i (rd_lower[i+1]),
        .rd_next_upper_i (rd_upper[i+1]),
        .rd_next_dist_i  (rd_dist[i+1]),
        .rd_lower_o      (rd_lower[i]),
        .rd_upper_o      (rd_upper[i]),
        .rd_dist_o       (rd_dist[i])
      );
    end
  end

  // Sequence one item at a time
  always_comb begin
    state_d       = state_q;
    point_count_d = point_count_q;
    pair_count_d  = pair_count_q;
    idx_d         = idx_q;
    issue_d       = issue_q;
    added_d       = added_q;
    rank_cnt_d    = rank_cnt_q;
    new_x_d       = new_x_q;
    new_y_d       = new_y_q;
    lo2_d         = lo2_q;
    hi2_d         = hi2_q;
    pend_d        = pend_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q;
    dist_wr       = 1'b0;
    dist_issue    = 1'b0;
    ctrl          = '0;
    ctrl.cmp_dist = dres_dist;

    // drop the result once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          pend_d   = '0;
          state_d  = StFinish;
          case (in_item_i.func)
            FuncAdd: begin
              if (point_count_q >= PC_W'(MAX_LANDMARKS)) begin
                pend_d.store_full = 1'b1;
                pend_d.pair_total = 7'(pair_count_q);
              end else begin
                dist_wr       = 1'b1;
                idx_d         = IDX_W'(point_count_q);
                point_count_d = point_count_q + 1'b1;
                issue_d       = '0;
                added_d       = '0;
                new_x_d       = in_item_i.landmark_x;
                new_y_d       = in_item_i.landmark_y;
                lo2_d         = win_lo_q * win_lo_q;
                hi2_d         = win_hi_q * win_hi_q;
                state_d       = StAdd;
              end
            end
            FuncRead: begin
              if ((CMP_W'(in_item_i.rank) < CMP_W'(pair_count_q)) &&
                  (CMP_W'(in_item_i.rank) < CMP_W'(PAIR_CAPACITY))) begin
                ctrl.rd_load = 1'b1;
                rank_cnt_d   = in_item_i.rank;
                state_d      = StRead;
              end else begin
                pend_d.pair_total = 7'(pair_count_q);
              end
            end
            FuncClear: begin
              point_count_d = '0;
              pair_count_d  = '0;
            end
            default: begin
              pend_d.pair_total = 7'(pair_count_q);
            end
          endcase
        end
      end

      StAdd: begin
        // issue the next earlier landmark
        if (issue_q != idx_q) begin
          dist_issue = 1'b1;
          issue_d    = issue_q + 1'b1;
        end
        // insert a kept pair while there is room
        if (dres_valid && dres_keep && (pair_count_q < CNT_W'(PAIR_CAPACITY))) begin
          ctrl.insert  = 1'b1;
          pair_count_d = pair_count_q + 1'b1;
          added_d      = added_q + 1'b1;
        end
        if ((issue_q == idx_q) && !dist_busy) begin
          pend_d                    = '0;
          pend_d.new_landmark_index = 4'(idx_q);
          pend_d.pairs_added        = 4'(added_q);
          pend_d.pair_total         = 7'(pair_count_q);
          state_d                   = StFinish;
        end
      end

      StRead: begin
        if (rank_cnt_q == '0) begin
          pend_d             = '0;
          pend_d.entry_valid = 1'b1;
          pend_d.lower_index = 4'(rd_lower[0]);
          pend_d.upper_index = 4'(rd_upper[0]);
          pend_d.distance_sq = rd_dist[0];
          pend_d.pair_total  = 7'(pair_count_q);
          state_d            = StFinish;
        end else begin
          ctrl.rd_shift = 1'b1;
          rank_cnt_d    = rank_cnt_q - 1'b1;
        end
      end

      StFinish: begin
        // hand over once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_d       = pend_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      point_count_q <= '0;
      pair_count_q  <= '0;
      out_valid_q   <= 1'b0;
      win_lo_q      <= MinSideReset;
      win_hi_q      <= MaxSideReset;
    end else begin
      state_q       <= state_d;
      point_count_q <= point_count_d;
      pair_count_q  <= pair_count_d;
      out_valid_q   <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegMinSide: win_lo_q <= cfg_data_i;
          RegMaxSide: win_hi_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Working registers and payload
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    issue_q    <= issue_d;
    added_q    <= added_d;
    rank_cnt_q <= rank_cnt_d;
    new_x_q    <= new_x_d;
    new_y_q    <= new_y_d;
    lo2_q      <= lo2_d;
    hi2_q      <= hi2_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

FILE: test/landmark_pair_distance_sorter_test.sv
module landmark_pair_distance_sorter_test;
  import lpds_pkg::*;

  localparam int unsigned NumLandmarks = 16;
  localparam int unsigned PairCapacity = 120;
  localparam logic [1:0]  FuncUnused   = 2'd3;
  localparam int          CoordBase    = -524288;
  localparam int          CoordTop     = 524287;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [15:0]          cfg_data = '0;

  // Predicted block state
  longint               lm_x [NumLandmarks];
  longint               lm_y [NumLandmarks];
  int                   lm_count = 0;
  int                   pr_lo [PairCapacity];
  int                   pr_hi [PairCapacity];
  longint               pr_dsq [PairCapacity];
  int                   pr_count = 0;
  logic [15:0]          win_lo = MinSideReset;
  logic [15:0]          win_hi = MaxSideReset;

  out_item_t            pair_results_due [$];
  int                   fail_count = 0;
  int                   items_sent = 0;
  bit                   gaps_on = 1'b1;

  landmark_pair_distance_sorter #(
    .MAX_LANDMARKS(NumLandmarks),
    .PAIR_CAPACITY(PairCapacity)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int rnd_coord();
    return int'($urandom_range(0, 1048575)) + CoordBase;
  endfunction

  function automatic in_item_t make_item(input logic [1:0] func, input int x, input int y,
                                         input int rank);
    in_item_t it;
    it.func       = func;
    it.landmark_x = x[19:0];
    it.landmark_y = y[19:0];
    it.rank       = rank[6:0];
    return it;
  endfunction

  // Advance the predicted state by one item and return the result it gives
  function automatic out_item_t apply_landmark_item(input in_item_t it);
    out_item_t res;
    longint    x, y, dx, dy, dsq, lo2, hi2;
    int        e, k, pos, added;
    res = '0;
    case (it.func)
      FuncAdd: begin
        if (lm_count >= NumLandmarks) begin
          res.store_full = 1'b1;
        end else begin
          x     = longint'($signed(it.landmark_x));
          y     = longint'($signed(it.landmark_y));
          lo2   = longint'(win_lo) * longint'(win_lo);
          hi2   = longint'(win_hi) * longint'(win_hi);
          added = 0;
          for (e = 0; e < lm_count; e++) begin
            dx  = x - lm_x[e];
            dy  = y - lm_y[e];
            dsq = dx * dx + dy * dy;
            // insert after every entry of equal or greater distance
            if (dsq >= lo2 && dsq <= hi2 && pr_count < PairCapacity) begin
              pos = 0;
              while (pos < pr_count && pr_dsq[pos] >= dsq) pos++;
              for (k = pr_count; k > pos; k--) begin
                pr_lo[k]  = pr_lo[k-1];
                pr_hi[k]  = pr_hi[k-1];
                pr_dsq[k] = pr_dsq[k-1];
              end
              pr_lo[pos]  = e;
              pr_hi[pos]  = lm_count;
              pr_dsq[pos] = dsq;
              pr_count++;
              added++;
            end
          end
          lm_x[lm_count]         = x;
          lm_y[lm_count]         = y;
          res.new_landmark_index = 4'(lm_count);
          res.pairs_added        = 4'(added);
          lm_count++;
        end
      end
      FuncRead: begin
        if (int'(it.rank) < pr_count) begin
          res.entry_valid = 1'b1;
          res.lower_index = 4'(pr_lo[it.rank]);
          res.upper_index = 4'(pr_hi[it.rank]);
          res.distance_sq = 32'(pr_dsq[it.rank]);
        end
      end
      FuncClear: begin
        lm_count = 0;
        pr_count = 0;
      end
      default: ;
    endcase
    res.pair_total = 7'(pr_count);
    return res;
  endfunction

  // Hold the item until taken, then log its predicted result
  task automatic send_item(input in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    pair_results_due.insert(pair_results_due.size(), apply_landmark_item(it));
    items_sent++;
  endtask

  task automatic send_read(input int rank);
    send_item(make_item(FuncRead, rnd_coord(), rnd_coord(), rank));
  endtask

  task automatic send_add(input int x, input int y);
    send_item(make_item(FuncAdd, x, y, $urandom_range(0, 127)));
  endtask

  task automatic send_clear();
    send_item(make_item(FuncClear, rnd_coord(), rnd_coord(), $urandom_range(0, 127)));
  endtask

  // Drop valid and wait for every outstanding result
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pair_results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == RegMinSide) win_lo = data;
    else if (idx == RegMaxSide) win_hi = data;
  endtask

  task automatic write_window(input logic [15:0] lo, input logic [15:0] hi);
    write_reg(RegMinSide, lo);
    write_reg(RegMaxSide, hi);
    cfg_valid <= 1'b0;
  endtask

  // Output back-pressure: random stall bursts between short runs
  initial begin
    int n;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Check each result taken against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pair_results_due.size() == 0) begin
        $error("result with no item outstanding: pair_total %0d", out_item.pair_total);
        fail_count++;
      end else begin
        want = pair_results_due[0];
        pair_results_due.delete(0);
        compare_field("store_full", want.store_full, out_item.store_full);
        compare_field("new_landmark_index", want.new_landmark_index,
                      out_item.new_landmark_index);
        compare_field("pairs_added", want.pairs_added, out_item.pairs_added);
        compare_field("pair_total", want.pair_total, out_item.pair_total);
        compare_field("entry_valid", want.entry_valid, out_item.entry_valid);
        compare_field("lower_index", want.lower_index, out_item.lower_index);
        compare_field("upper_index", want.upper_index, out_item.upper_index);
        compare_field("distance_sq", want.distance_sq, out_item.distance_sq);
      end
    end
  end

  // Coordinate extremes, window edges, equal distances, out-of-range ranks
  task automatic test_directed_ops();
    send_read(0);
    send_add(CoordBase, CoordBase);
    send_add(CoordTop, CoordTop);
    send_add(CoordBase + 3000, CoordBase + 4000);
    send_add(CoordBase, CoordBase + 5000);
    send_add(CoordBase + 2000, CoordBase);
    send_add(CoordBase + 20000, CoordBase);
    send_item(make_item(FuncUnused, rnd_coord(), rnd_coord(), $urandom_range(0, 127)));
    send_read(0);
    send_read(pr_count - 1);
    send_read(119);
    send_read(127);
  endtask

  // Fill the landmark store, add once more, then read around a clear
  task automatic test_full_store();
    int k;
    for (k = lm_count; k < NumLandmarks; k++)
      send_add(CoordBase + $urandom_range(0, 15000), CoordBase + $urandom_range(0, 15000));
    send_add(rnd_coord(), rnd_coord());
    send_read(0);
    send_clear();
    send_read(0);
  endtask

  // Min above max keeps nothing
  task automatic test_inverted_window();
    wait_idle();
    write_window(16'd20000, 16'd2000);
    send_clear();
    send_add(0, 0);
    send_add(5000, 0);
    send_add(0, 10000);
    send_read(0);
    wait_idle();
    write_window(MinSideReset, MaxSideReset);
  endtask

  // Phases of landmark sessions under a range of windows
  task automatic test_random_sessions();
    int          phase, phase_end, run_end, n_adds, k, r, cx, cy, step, span;
    bit          grid;
    logic [15:0] lo, hi;
    phase   = 0;
    run_end = items_sent + 1950;
    while (items_sent < run_end) begin
      case (phase)
        0: begin lo = 16'd2000;  hi = 16'd20000; end
        1: begin lo = 16'd0;     hi = 16'd65535; end
        2: begin lo = 16'd0;     hi = 16'd0;     end
        3: begin lo = 16'd65535; hi = 16'd65535; end
        4: begin lo = 16'd65535; hi = 16'd0;     end
        5: begin lo = 16'd3000;  hi = 16'd3000;  end
        default: begin
          if ($urandom_range(0, 4) == 0) begin
            lo = 16'($urandom());
            hi = 16'($urandom());
          end else begin
            lo = 16'($urandom_range(0, 20000));
            hi = lo + 16'($urandom_range(0, 65535 - lo));
          end
        end
      endcase
      wait_idle();
      write_window(lo, hi);
      gaps_on   = (phase % 4 != 3);
      phase_end = items_sent + 150;
      while (items_sent < phase_end) begin
        // session geometry: a grid hits exact distances and duplicates
        cx   = int'($urandom_range(0, 648574)) - 324287;
        cy   = int'($urandom_range(0, 648574)) - 324287;
        grid = ($urandom_range(0, 9) < 4);
        r    = $urandom_range(0, 2);
        step = (r == 0) ? int'(win_lo) : (r == 1) ? int'(win_hi) :
               int'($urandom_range(1, 65535));
        span = int'(win_hi) + int'(win_hi) / 4 + 500;
        if (span > 80000) span = 80000;
        n_adds = ($urandom_range(0, 5) == 0) ? $urandom_range(16, 19) : $urandom_range(2, 16);
        send_clear();
        for (k = 0; k < n_adds; k++) begin
          r = $urandom_range(0, 99);
          if (r < 4) begin
            send_add(rnd_coord(), rnd_coord());
          end else if (r < 7) begin
            send_item(make_item(FuncUnused, rnd_coord(), rnd_coord(),
                                $urandom_range(0, 127)));
          end else if (r < 9) begin
            send_clear();
          end else if (grid) begin
            send_add(cx + step * int'($urandom_range(0, 3)),
                     cy + step * int'($urandom_range(0, 3)));
          end else begin
            send_add(cx + int'($urandom_range(0, 2 * span)) - span,
                     cy + int'($urandom_range(0, 2 * span)) - span);
          end
          if ($urandom_range(0, 2) == 0) send_read($urandom_range(0, 127));
        end
        repeat ($urandom_range(2, 8)) begin
          if ($urandom_range(0, 9) == 0 || pr_count == 0) send_read($urandom_range(0, 127));
          else send_read($urandom_range(0, pr_count - 1));
        end
      end
      phase++;
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_ops();
    test_full_store();
    test_inverted_window();
    test_random_sessions();
    wait_idle();
    // allow for the longest read before judging
    repeat (150) @(posedge clk);
    if (fail_count == 0 && pair_results_due.size() == 0) begin
      $display("landmark_pair_distance_sorter_test OK");
    end else begin
      $display("landmark_pair_distance_sorter_test NOT OK");
    end
    $finish;
  end

  initial begin
    #16000000;
    $display("landmark_pair_distance_sorter_test NOT OK");
    $finish;
  end

endmodule
